@@ hdl/fbpa_pkg.sv @@
// Shared types, constants and codes of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int NUM_POOLS    = 4;
    localparam int MAX_PER_POOL = 16;
    localparam int TOTAL_SLOTS  = 64;

    localparam int SLOT_W   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int TAG_W    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int IDX_W    = (MAX_PER_POOL > 1) ? $clog2(MAX_PER_POOL) : 1;
    localparam int CNT_W    = $clog2(MAX_PER_POOL + 1);

    // Fixed field widths of the stream words and registers
    localparam int MODE_W     = 2;
    localparam int POOL_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int HANDLE_W   = 6;
    localparam int OFFSET_W   = 21;
    localparam int COUNT_W    = 5;
    localparam int PBYTES_W   = 20;
    localparam int SIZE_W     = 16;
    localparam int PARTS_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_POOLS  = 4;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 80;

    // Shift-add multiplier: multiplier up to CNT_W bits, multiplicand size+1
    localparam int MC_W      = SIZE_W + 1;
    localparam int PROD_W    = CNT_W + MC_W;
    localparam int MUL_STEPS = CNT_W;
    localparam int STEP_W    = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END        = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INFO  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOFREE     = 2'd1,
        ST_BADPOOL    = 2'd2,
        ST_BADHANDLE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DECODE,
        FSM_SCAN,
        FSM_ALLOC_WR,
        FSM_FREE_CHK,
        FSM_MUL_WAIT,
        FSM_DONE
    } fsm_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              wr_used;
        logic [TAG_W-1:0]  wr_tag;
    } store_req_t;

    typedef struct packed {
        logic             used;
        logic [TAG_W-1:0] tag;
    } store_rsp_t;

endpackage

@@ hdl/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator: sequencer, pool counters, registers.
`timescale 1ns / 1ps

// Four pools of fixed-size partitions share one 64-entry slot status store;
// pool p owns slots p*16 onward. Each input word is a request (allocate, free
// or pool information) and gives exactly one result word. The block takes one
// request at a time: s_tready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next request is
// taken. An allocate scans at most 16 slots of its pool: the status store is
// read one slot per cycle through a registered read, and the byte offset
// idx*(size+1)+1 comes from a shift-add multiplier that runs five steps and
// then flags done. Pool information also uses that multiplier. The sequencer
// is idle again in the cycle after the result is loaded; a result word still
// held in the output register stalls the sequencer until it is taken.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream. s_tdata: mode[1:0], pool[5:2], slot[11:6], zeros above
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    // Result stream. m_tdata: status[1:0], handle[7:2], data_offset[28:8],
    // used_count[33:29], free_count[38:34], pool_bytes[58:39],
    // partition_bytes[74:59], zeros above
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    // Register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fsm_state_t state_reg, state_next;

    // Configuration registers
    logic [PARTS_W-1:0] parts_reg [CFG_POOLS];
    logic [SIZE_W-1:0]  bytes_reg [CFG_POOLS];

    // Used partitions per pool
    logic [CNT_W-1:0] pool_used_reg [NUM_POOLS];

    // Request held for the whole job
    logic [MODE_W-1:0] mode_reg;
    logic [POOL_W-1:0] pool_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Scan control: issue index and the slot whose read data is due
    logic [CNT_W-1:0] idx_reg;
    logic             chk_vld_reg;
    logic             chk_ok_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    // Working result
    logic [STATUS_W-1:0] status_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COUNT_W-1:0]  used_cnt_reg;
    logic [COUNT_W-1:0]  free_cnt_reg;
    logic [PBYTES_W-1:0] pbytes_reg;
    logic [SIZE_W-1:0]   psize_reg;

    // Output register
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    store_req_t        st_req;
    store_rsp_t        st_rsp;
    logic              mul_start;
    logic [MC_W-1:0]   mul_mcand;
    logic [CNT_W-1:0]  mul_mplier;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;

    logic              pool_ok;
    logic [TAG_W-1:0]  pool_sel;
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  used_now;
    logic [SIZE_W-1:0] size_now;
    logic              scan_more;
    logic              found;
    logic              issue_ok;
    logic [SLOT_W-1:0] issue_addr;
    logic [SLOT_W-1:0] alloc_addr;
    logic              in_acc;
    logic              out_load;
    logic [OUT_W-1:0]  result_word;

    fbpa_slot_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (st_req),
        .rsp   (st_rsp)
    );

    fbpa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    // Pool figures for the held request
    assign pool_ok  = (int'(pool_reg) < NUM_POOLS);
    assign pool_sel = pool_reg[TAG_W-1:0];
    assign used_now = pool_used_reg[pool_sel];

    always_comb
    begin
        cap      = '0;
        size_now = '0;
        if (int'(pool_sel) < CFG_POOLS)
        begin
            size_now = bytes_reg[pool_sel];
            if (int'(parts_reg[pool_sel]) > MAX_PER_POOL)
            begin
                cap = CNT_W'(MAX_PER_POOL);
            end
            else
            begin
                cap = CNT_W'(parts_reg[pool_sel]);
            end
        end
    end

    assign scan_more  = (idx_reg < cap);
    assign issue_ok   = (int'(pool_sel) * MAX_PER_POOL + int'(idx_reg)) < TOTAL_SLOTS;
    assign issue_addr = SLOT_W'(int'(pool_sel) * MAX_PER_POOL + int'(idx_reg));
    assign alloc_addr = SLOT_W'(int'(pool_sel) * MAX_PER_POOL + int'(chk_idx_reg));
    assign found      = chk_vld_reg && chk_ok_reg && !st_rsp.used;

    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == FSM_DONE) && (!m_valid_reg || m_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = FSM_DECODE;
                end
            end
            FSM_DECODE:
            begin
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (!pool_ok || (used_now >= cap))
                        begin
                            state_next = FSM_DONE;
                        end
                        else
                        begin
                            state_next = FSM_SCAN;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (int'(slot_reg) < TOTAL_SLOTS)
                        begin
                            state_next = FSM_FREE_CHK;
                        end
                        else
                        begin
                            state_next = FSM_DONE;
                        end
                    end
                    MODE_INFO:
                    begin
                        if (pool_ok)
                        begin
                            state_next = FSM_MUL_WAIT;
                        end
                        else
                        begin
                            state_next = FSM_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = FSM_DONE;
                    end
                endcase
            end
            FSM_SCAN:
            begin
                if (found)
                begin
                    state_next = FSM_ALLOC_WR;
                end
                else if (!scan_more && !chk_vld_reg)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_ALLOC_WR:
            begin
                state_next = FSM_MUL_WAIT;
            end
            FSM_FREE_CHK:
            begin
                state_next = FSM_DONE;
            end
            FSM_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Store and multiplier requests
    always_comb
    begin
        st_req     = '0;
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        s_tready   = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
            end
            FSM_DECODE:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    st_req.rd_en   = 1'b1;
                    st_req.rd_addr = slot_reg;
                end
                else if ((mode_reg == MODE_INFO) && pool_ok)
                begin
                    mul_start  = 1'b1;
                    mul_mcand  = MC_W'(size_now);
                    mul_mplier = cap;
                end
            end
            FSM_SCAN:
            begin
                if (!found && scan_more)
                begin
                    st_req.rd_en   = 1'b1;
                    st_req.rd_addr = issue_addr;
                end
            end
            FSM_ALLOC_WR:
            begin
                st_req.wr_en   = 1'b1;
                st_req.wr_addr = alloc_addr;
                st_req.wr_used = 1'b1;
                st_req.wr_tag  = pool_sel;
                mul_start      = 1'b1;
                mul_mcand      = MC_W'(size_now) + MC_W'(1);
                mul_mplier     = CNT_W'(chk_idx_reg);
            end
            FSM_FREE_CHK:
            begin
                if (st_rsp.used)
                begin
                    st_req.wr_en   = 1'b1;
                    st_req.wr_addr = slot_reg;
                    st_req.wr_used = 1'b0;
                    st_req.wr_tag  = '0;
                end
            end
            default:
            begin
                st_req = '0;
            end
        endcase
    end

    // Control state, counters and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
            idx_reg     <= '0;
            for (int p = 0; p < NUM_POOLS; p++)
            begin
                pool_used_reg[p] <= '0;
            end
            for (int c = 0; c < CFG_POOLS; c++)
            begin
                parts_reg[c] <= '0;
                bytes_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == FSM_DECODE)
            begin
                idx_reg     <= '0;
                chk_vld_reg <= 1'b0;
            end
            else if ((state_reg == FSM_SCAN) && !found)
            begin
                chk_vld_reg <= scan_more;
                if (scan_more)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end

            // Count the slot in its pool; drop the count on a free
            if (state_reg == FSM_ALLOC_WR)
            begin
                pool_used_reg[pool_sel] <= used_now + CNT_W'(1);
            end
            else if ((state_reg == FSM_FREE_CHK) && st_rsp.used)
            begin
                if ((int'(st_rsp.tag) < NUM_POOLS) && (pool_used_reg[st_rsp.tag] != '0))
                begin
                    pool_used_reg[st_rsp.tag] <= pool_used_reg[st_rsp.tag] - CNT_W'(1);
                end
            end

            if (cfg_valid)
            begin
                if (cfg_index < CFG_BYTES_BASE)
                begin
                    parts_reg[TAG_W'(cfg_index - CFG_PARTS_BASE)] <= cfg_data[PARTS_W-1:0];
                end
                else if (cfg_index < CFG_END)
                begin
                    bytes_reg[TAG_W'(cfg_index - CFG_BYTES_BASE)] <= cfg_data;
                end
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg     <= s_tdata[MODE_W-1:0];
            pool_reg     <= s_tdata[MODE_W +: POOL_W];
            slot_reg     <= s_tdata[MODE_W+POOL_W +: SLOT_W];
            status_reg   <= ST_BADHANDLE;
            handle_reg   <= '0;
            offset_reg   <= '0;
            used_cnt_reg <= '0;
            free_cnt_reg <= '0;
            pbytes_reg   <= '0;
            psize_reg    <= '0;
        end

        case (state_reg)
            FSM_DECODE:
            begin
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (!pool_ok)
                        begin
                            status_reg <= ST_BADPOOL;
                        end
                        else
                        begin
                            status_reg <= ST_NOFREE;
                        end
                    end
                    MODE_INFO:
                    begin
                        if (!pool_ok)
                        begin
                            status_reg <= ST_BADPOOL;
                        end
                        else
                        begin
                            status_reg   <= ST_OK;
                            used_cnt_reg <= COUNT_W'(used_now);
                            free_cnt_reg <= (cap > used_now) ? COUNT_W'(cap - used_now) : '0;
                            psize_reg    <= size_now;
                        end
                    end
                    default:
                    begin
                        status_reg <= ST_BADHANDLE;
                    end
                endcase
            end
            FSM_SCAN:
            begin
                if (!found && scan_more)
                begin
                    chk_idx_reg <= idx_reg[IDX_W-1:0];
                    chk_ok_reg  <= issue_ok;
                end
            end
            FSM_ALLOC_WR:
            begin
                status_reg <= ST_OK;
                handle_reg <= HANDLE_W'(alloc_addr);
            end
            FSM_FREE_CHK:
            begin
                if (st_rsp.used)
                begin
                    status_reg <= ST_OK;
                end
            end
            FSM_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        offset_reg <= OFFSET_W'(mul_product) + OFFSET_W'(1);
                    end
                    else
                    begin
                        pbytes_reg <= PBYTES_W'(mul_product);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            m_data_reg <= result_word;
        end
    end

    // Pack the result word, first field lowest
    assign result_word = OUT_W'({psize_reg, pbytes_reg, free_cnt_reg, used_cnt_reg,
                                 offset_reg, handle_reg, status_reg});

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hdl/fbpa_slot_store.sv @@
// Slot status store: used mark and pool tag per slot, registered read.
`timescale 1ns / 1ps

module fbpa_slot_store
    import fbpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output store_rsp_t rsp
);

    logic [TAG_W:0]         mem [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] vld_reg;
    logic                   rd_vld_reg;
    logic [TAG_W:0]         rd_data_reg;

    // Written marks: an entry never written reads as unused
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= {req.wr_used, req.wr_tag};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rsp.used = rd_vld_reg & rd_data_reg[TAG_W];
    assign rsp.tag  = rd_vld_reg ? rd_data_reg[TAG_W-1:0] : '0;

endmodule

@@ hdl/fbpa_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module fbpa_mul
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MC_W-1:0]   mcand,
    input  logic [CNT_W-1:0]  mplier,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] mc_reg;
    logic [CNT_W-1:0]  mp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Add the shifted multiplicand where the multiplier bit is set
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= PROD_W'(mcand);
            mp_reg  <= mplier;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= {mc_reg[PROD_W-2:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[CNT_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ test/fbpa_result_monitor.sv @@
// Result monitor of the pool allocator test: predicts every result word and compares it.
`timescale 1ns / 1ps

module fbpa_result_monitor
    import fbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    // Bit positions of the result word fields
    localparam int HD_LSB = STATUS_W;
    localparam int OF_LSB = HD_LSB + HANDLE_W;
    localparam int UC_LSB = OF_LSB + OFFSET_W;
    localparam int FC_LSB = UC_LSB + COUNT_W;
    localparam int PB_LSB = FC_LSB + COUNT_W;
    localparam int SZ_LSB = PB_LSB + PBYTES_W;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  used_cnt;
        logic [COUNT_W-1:0]  free_cnt;
        logic [PBYTES_W-1:0] pool_bytes;
        logic [SIZE_W-1:0]   part_size;
    } pool_reply_t;

    logic               slot_busy  [TOTAL_SLOTS];
    logic [TAG_W-1:0]   slot_owner [TOTAL_SLOTS];
    int unsigned        in_use     [NUM_POOLS];
    logic [PARTS_W-1:0] part_count [CFG_POOLS];
    logic [SIZE_W-1:0]  size_cfg   [CFG_POOLS];
    pool_reply_t        awaited_replies [$];

    function automatic int unsigned usable_parts(input int unsigned pl);
        int unsigned n;
        n = part_count[pl];
        return (n > MAX_PER_POOL) ? MAX_PER_POOL : n;
    endfunction

    // Apply one request to the pool state and return its result word.
    function automatic pool_reply_t serve_request(input logic [IN_W-1:0] word);
        logic [MODE_W-1:0] md;
        int unsigned       pl;
        int unsigned       sl;
        int unsigned       cap;
        int unsigned       idx;
        int unsigned       s;
        int unsigned       owner;
        bit                hit;
        pool_reply_t       r;
        md           = word[MODE_W-1:0];
        pl           = word[MODE_W +: POOL_W];
        sl           = word[MODE_W+POOL_W +: HANDLE_W];
        r.status     = ST_BADHANDLE;
        r.handle     = '0;
        r.offset     = '0;
        r.used_cnt   = '0;
        r.free_cnt   = '0;
        r.pool_bytes = '0;
        r.part_size  = '0;
        case (md)
            MODE_ALLOC:
            begin
                if (pl >= NUM_POOLS)
                    r.status = ST_BADPOOL;
                else
                begin
                    cap      = usable_parts(pl);
                    r.status = ST_NOFREE;
                    hit      = 1'b0;
                    if (in_use[pl] < cap)
                    begin
                        // lowest free usable slot of the pool wins
                        for (idx = 0; idx < cap && !hit; idx++)
                        begin
                            s = pl * MAX_PER_POOL + idx;
                            if (s < TOTAL_SLOTS && !slot_busy[s])
                            begin
                                slot_busy[s]  = 1'b1;
                                slot_owner[s] = TAG_W'(pl);
                                in_use[pl]++;
                                r.handle = HANDLE_W'(s);
                                r.offset = OFFSET_W'(idx * (size_cfg[pl] + 1) + 1);
                                r.status = ST_OK;
                                hit      = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_FREE:
            begin
                if (sl < TOTAL_SLOTS && slot_busy[sl])
                begin
                    owner          = slot_owner[sl];
                    slot_busy[sl]  = 1'b0;
                    slot_owner[sl] = '0;
                    if (owner < NUM_POOLS && in_use[owner] > 0)
                        in_use[owner]--;
                    r.status = ST_OK;
                end
            end
            MODE_INFO:
            begin
                if (pl >= NUM_POOLS)
                    r.status = ST_BADPOOL;
                else
                begin
                    cap          = usable_parts(pl);
                    r.used_cnt   = COUNT_W'(in_use[pl]);
                    // saturate at zero once a pool has been shrunk below its use
                    r.free_cnt   = COUNT_W'((cap > in_use[pl]) ? cap - in_use[pl] : 0);
                    r.part_size  = size_cfg[pl];
                    r.pool_bytes = PBYTES_W'(cap * size_cfg[pl]);
                    r.status     = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic string reply_text(input pool_reply_t r);
        return $sformatf("status %0d handle %0d offset %0d used %0d free %0d bytes %0d size %0d",
                         r.status, r.handle, r.offset, r.used_cnt, r.free_cnt,
                         r.pool_bytes, r.part_size);
    endfunction

    task automatic check_reply(input logic [OUT_W-1:0] word);
        pool_reply_t want;
        pool_reply_t got;
        got.status     = word[STATUS_W-1:0];
        got.handle     = word[HD_LSB +: HANDLE_W];
        got.offset     = word[OF_LSB +: OFFSET_W];
        got.used_cnt   = word[UC_LSB +: COUNT_W];
        got.free_cnt   = word[FC_LSB +: COUNT_W];
        got.pool_bytes = word[PB_LSB +: PBYTES_W];
        got.part_size  = word[SZ_LSB +: SIZE_W];
        if (awaited_replies.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mon: unexpected result word: %s", reply_text(got));
        end
        else
        begin
            want = awaited_replies.pop_front();
            if (got.status !== want.status || got.handle !== want.handle ||
                got.offset !== want.offset || got.used_cnt !== want.used_cnt ||
                got.free_cnt !== want.free_cnt || got.pool_bytes !== want.pool_bytes ||
                got.part_size !== want.part_size)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mon: mismatch at %0t\n  expected %s\n  actual   %s",
                             $realtime, reply_text(want), reply_text(got));
            end
        end
    endtask

    // Sample between rising edges: every handshake signal is settled by then.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_SLOTS; i++)
            begin
                slot_busy[i]  = 1'b0;
                slot_owner[i] = '0;
            end
            for (int i = 0; i < NUM_POOLS; i++)
                in_use[i] = 0;
            for (int i = 0; i < CFG_POOLS; i++)
            begin
                part_count[i] = '0;
                size_cfg[i]   = '0;
            end
            awaited_replies.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_reply(m_tdata);
            if (s_tvalid && s_tready)
                awaited_replies.push_back(serve_request(s_tdata));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < CFG_BYTES_BASE)
                    part_count[TAG_W'(cfg_index - CFG_PARTS_BASE)] = cfg_data[PARTS_W-1:0];
                else if (cfg_index < CFG_END)
                    size_cfg[TAG_W'(cfg_index - CFG_BYTES_BASE)] = cfg_data;
            end
            pending = awaited_replies.size();
        end
    end

endmodule

@@ test/fixed_block_pool_allocator_tb.sv @@
// Testbench top of the fixed block pool allocator: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    // Mode code the block does not define; it must answer with a bad handle status
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;

    // Words still to send in the current burst; zero means a gap may come next
    int                    burst_left = 0;
    int unsigned           stall_tick = 0;

    // Pool setup to be loaded by the next configuration phase
    logic [PARTS_W-1:0]    setup_parts [CFG_POOLS];
    logic [SIZE_W-1:0]     setup_sizes [CFG_POOLS];

    always #2 clk = ~clk;

    fixed_block_pool_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Watch all three channels, predict and compare; hand back failures and backlog
    fbpa_result_monitor u_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver back-pressure: cycle through four styles in turn -
    // always ready, coin toss, short regular stalls, and long stalls that let
    // the result register sit full while the next request is already taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_tick <= 0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            case (stall_tick[9:8])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
                2'd2:    m_tready <= (stall_tick[3:0] < 4'd11);
                default: m_tready <= (stall_tick[3:0] == 4'd0);
            endcase
        end
    end

    // Present one register write from a rising edge and hold it until taken.
    // Leave cfg_valid high on return; the caller drops it after the last write.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drop the request valid and hold off until every result word is back.
    // Always advance one edge first so valid is never lowered and raised in one step.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Load setup_parts and setup_sizes into all eight registers with the block idle.
    task automatic apply_setup();
        int i;
        drain_results();
        repeat (4) @(posedge clk);
        for (i = 0; i < CFG_POOLS; i++)
            put_reg(CFG_IDX_W'(CFG_PARTS_BASE + i), CFG_DATA_W'(setup_parts[i]));
        for (i = 0; i < CFG_POOLS; i++)
            put_reg(CFG_IDX_W'(CFG_BYTES_BASE + i), setup_sizes[i]);
        cfg_valid <= 1'b0;
    endtask

    // Send one request word. Between bursts insert a random gap; some bursts are
    // long, giving stretches with no sender idling at all.
    task automatic put_request(input logic [MODE_W-1:0] md, input logic [POOL_W-1:0] pl,
                               input logic [HANDLE_W-1:0] sl);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - MODE_W - POOL_W - HANDLE_W){1'b0}}, sl, pl, md};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        burst_left--;
    endtask

    // Mostly valid pools and handles inside the pool's own slot range, so that
    // frees hit live partitions; the rest is out-of-range pools and stray handles.
    task automatic random_request(input int alloc_pct);
        int unsigned         pick;
        logic [MODE_W-1:0]   md;
        logic [POOL_W-1:0]   pl;
        logic [HANDLE_W-1:0] sl;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
            md = MODE_ALLOC;
        else if (pick < 75)
            md = MODE_FREE;
        else if (pick < 95)
            md = MODE_INFO;
        else
            md = MODE_UNUSED;
        if ($urandom_range(0, 9) == 0)
            pl = POOL_W'($urandom_range(0, 15));
        else
            pl = POOL_W'($urandom_range(0, NUM_POOLS - 1));
        if (md == MODE_FREE && $urandom_range(0, 4) != 0)
            sl = HANDLE_W'((pl % NUM_POOLS) * MAX_PER_POOL +
                           $urandom_range(0, MAX_PER_POOL - 1));
        else
            sl = HANDLE_W'($urandom_range(0, TOTAL_SLOTS - 1));
        put_request(md, pl, sl);
    endtask

    initial
    begin
        int phase;
        int n;
        int alloc_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at reset: every pool is empty of partitions
        put_request(MODE_ALLOC, 4'd0, 6'd0);
        put_request(MODE_INFO, 4'd0, 6'd0);
        put_request(MODE_FREE, 4'd0, 6'd0);
        put_request(MODE_UNUSED, 4'd15, 6'd63);

        // Largest size, a one-partition pool, an oversized partition count
        // that must act as sixteen, and an odd size
        setup_parts = '{5'd16, 5'd1, 5'd31, 5'd5};
        setup_sizes = '{16'hFFFF, 16'd0, 16'd1, 16'hA5A5};
        apply_setup();
        // an unmapped register index must be ignored
        @(posedge clk);
        put_reg(CFG_END, 16'hFFFF);
        cfg_valid <= 1'b0;

        put_request(MODE_ALLOC, 4'd1, 6'd0);
        put_request(MODE_ALLOC, 4'd1, 6'd0);     // pool full
        put_request(MODE_ALLOC, 4'd0, 6'd0);
        put_request(MODE_ALLOC, 4'd0, 6'd0);
        put_request(MODE_ALLOC, 4'd2, 6'd0);
        put_request(MODE_ALLOC, 4'd3, 6'd0);
        put_request(MODE_ALLOC, 4'd4, 6'd0);     // first pool out of range
        put_request(MODE_ALLOC, 4'd15, 6'd63);
        put_request(MODE_INFO, 4'd15, 6'd0);
        put_request(MODE_INFO, 4'd0, 6'd0);
        put_request(MODE_INFO, 4'd1, 6'd0);
        put_request(MODE_INFO, 4'd2, 6'd0);
        put_request(MODE_INFO, 4'd3, 6'd0);
        put_request(MODE_FREE, 4'd0, 6'd16);
        put_request(MODE_FREE, 4'd0, 6'd16);     // double free
        put_request(MODE_FREE, 4'd0, 6'd63);     // never allocated
        put_request(MODE_FREE, 4'd0, 6'd1);
        put_request(MODE_ALLOC, 4'd0, 6'd0);     // reuse the freed lowest slot
        put_request(MODE_INFO, 4'd1, 6'd0);

        // Random phases. Keep the slot state across phases so that lowered
        // partition counts meet pools that are already in use.
        for (phase = 0; phase < 6; phase++)
        begin
            for (n = 0; n < CFG_POOLS; n++)
            begin
                case (phase)
                    0:
                    begin
                        setup_parts[n] = PARTS_W'(MAX_PER_POOL);
                        setup_sizes[n] = 16'hFFFF;
                    end
                    1:
                    begin
                        setup_parts[n] = PARTS_W'($urandom_range(0, MAX_PER_POOL));
                        setup_sizes[n] = SIZE_W'($urandom);
                    end
                    2:
                    begin
                        setup_parts[n] = PARTS_W'($urandom_range(0, 3));
                        setup_sizes[n] = SIZE_W'($urandom_range(0, 255));
                    end
                    3:
                    begin
                        setup_parts[n] = '0;
                        setup_sizes[n] = '0;
                    end
                    4:
                    begin
                        setup_parts[n] = PARTS_W'($urandom_range(0, 31));
                        setup_sizes[n] = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                     : SIZE_W'($urandom);
                    end
                    default:
                    begin
                        setup_parts[n] = PARTS_W'(MAX_PER_POOL);
                        setup_sizes[n] = SIZE_W'($urandom);
                    end
                endcase
            end
            apply_setup();
            // fill pools hard where every partition is usable, so the top slots are reached
            alloc_pct = (phase == 0 || phase == 5) ? 60 : $urandom_range(25, 55);
            for (n = 0; n < 222; n++)
            begin
                if (n == 111)
                    drain_results();
                random_request(alloc_pct);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
